// ===== rtl/core/bale_pkg.sv =====
// Shared constants, codes and types of the bounded array list engine.
package bale_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int OP_W         = 3;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int FOUND_W      = 5;
    localparam int COUNT_W      = 6;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_DEL_POS  = 3'd1,
        OP_DEL_VAL  = 3'd2,
        OP_FIND     = 3'd3,
        OP_READ     = 3'd4,
        OP_CLEAR    = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic [FOUND_W-1:0]        found_position;
        logic signed [WORD_W-1:0]  read_value;
        logic [COUNT_W-1:0]        count;
    } t_result;

endpackage

// ===== rtl/core/bale_if.sv =====
// Valid/ready channel interfaces for operations in and results out.
interface bale_in_if;
    import bale_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [WORD_W-1:0]  value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink (input valid, input op, input value, input position, output ready);
endinterface

interface bale_out_if;
    import bale_pkg::*;

    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic [FOUND_W-1:0]        found_position;
    logic signed [WORD_W-1:0]  read_value;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, output status, output found_position, output read_value,
                    output count, input ready);
    modport sink (input valid, input status, input found_position, input read_value,
                  input count, output ready);
endinterface

// ===== rtl/core/bale_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bale_seq.sv =====
// Operation sequencer: owns the entry count and walks the entry memory.
module bale_seq #(
    parameter int CAPACITY = bale_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bale_in_if.sink                          i_in,
    output bale_pkg::t_result                o_res,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output logic [bale_pkg::WORD_W-1:0]      o_wdata,
    output logic [AW-1:0]                    o_raddr,
    input  logic [bale_pkg::WORD_W-1:0]      i_rdata
);
    import bale_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int XW    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_READ   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]        r_idx, n_idx;
    logic [WORD_W-1:0]    r_value, n_value;
    logic                 r_del, n_del;
    t_status              r_status, n_status;
    logic [FOUND_W-1:0]   r_found, n_found;
    logic [WORD_W-1:0]    r_rd, n_rd;

    logic [XW-1:0]        pos_x;
    logic                 pos_ok;
    logic [CNT_W-1:0]     idx_p1;
    logic                 more;
    logic                 hit;

    assign pos_x  = XW'(i_in.position);
    assign pos_ok = pos_x < XW'(r_cnt);
    assign idx_p1 = CNT_W'(r_idx) + CNT_W'(1);
    assign more   = idx_p1 < r_cnt;
    assign hit    = i_rdata == r_value;

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_value  = r_value;
        n_del    = r_del;
        n_status = r_status;
        n_found  = r_found;
        n_rd     = r_rd;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = i_rdata;
        o_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_status = ST_OK;
                    n_found  = '0;
                    n_rd     = '0;
                    n_value  = i_in.value;
                    n_del    = 1'b0;
                    n_state  = S_EMIT;
                    unique case (t_op'(i_in.op))
                        OP_APPEND: begin
                            if (r_cnt >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = AW'(r_cnt);
                                o_wdata = i_in.value;
                                n_cnt   = r_cnt + CNT_W'(1);
                            end
                        end
                        OP_DEL_POS: begin
                            if (!pos_ok) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_idx   = AW'(i_in.position);
                                o_raddr = AW'(pos_x + XW'(1));
                                n_state = S_SHIFT;
                            end
                        end
                        OP_DEL_VAL, OP_FIND: begin
                            n_del = (t_op'(i_in.op) == OP_DEL_VAL);
                            if (r_cnt == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_idx   = '0;
                                o_raddr = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        OP_READ: begin
                            if (!pos_ok) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                o_raddr = AW'(i_in.position);
                                n_state = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_found = FOUND_W'(r_idx);
                    if (r_del) begin
                        o_raddr = AW'(idx_p1);
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else if (more) begin
                    n_idx   = r_idx + AW'(1);
                    o_raddr = AW'(idx_p1);
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (more) begin
                    o_we    = 1'b1;
                    o_waddr = r_idx;
                    o_wdata = i_rdata;
                    n_idx   = r_idx + AW'(1);
                    o_raddr = AW'(idx_p1 + CNT_W'(1));
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                n_rd    = i_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_del    <= n_del;
        r_status <= n_status;
        r_found  <= n_found;
        r_rd     <= n_rd;
    end

    assign o_res_valid          = (r_state == S_EMIT);
    assign o_res.status         = r_status;
    assign o_res.found_position = r_found;
    assign o_res.read_value     = r_rd;
    assign o_res.count          = COUNT_W'(r_cnt);

endmodule

// ===== rtl/core/bale_out_stage.sv =====
// Output register that holds one result until the consumer takes it.
module bale_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bale_pkg::t_result  i_res,
    output logic               o_ready,
    bale_out_if.source         o_out
);
    import bale_pkg::*;

    logic     r_valid;
    t_result  r_res;

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.status         = r_res.status;
    assign o_out.found_position = r_res.found_position;
    assign o_out.read_value     = r_res.read_value;
    assign o_out.count          = r_res.count;

endmodule

// ===== rtl/core/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine: sequencer, entry memory and output register.
//
//  channel | direction | payload                                    | transfer when
//  i_in    | in        | op, value, position                        | valid && ready
//  o_out   | out       | status, found_position, read_value, count  | valid && ready
//
// One operation is in work at a time; the entry memory has one write and one read port.
// Append, clear and operations refused at the start go straight to the result; read at
// a position passes through the read state. Find searches up from index 0 until a hit or
// the end of the list; delete by value then shifts the later entries down, like delete at position.
// Reset clears the count and the control state; the entry memory is not cleared.
// A result waiting in the output register does not stop the next operation from starting.
module bounded_array_list_engine #(
    parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bale_in_if.sink     i_in,
    bale_out_if.source  o_out
);
    import bale_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    t_result            res;
    logic               res_valid;
    logic               res_ready;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [WORD_W-1:0]  wdata;
    logic [AW-1:0]      raddr;
    logic [WORD_W-1:0]  rdata;

    bale_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    bale_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bale_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (res_ready),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/bale_checker.sv =====
// Port-level assertions for the bounded array list engine and their bind.
module bale_checker #(
    parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input bale_pkg::t_status             i_status,
    input logic [bale_pkg::FOUND_W-1:0]  i_found,
    input logic [bale_pkg::WORD_W-1:0]   i_rd,
    input logic [bale_pkg::COUNT_W-1:0]  i_count
);
    import bale_pkg::*;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("A second operation was taken right after a transfer.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CAPACITY > 63) || (i_count <= CAPACITY))
        else $error("The reported count exceeds the capacity.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_count == COUNT_W'(CAPACITY))
        else $error("A full status came with a count below the capacity.");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_rd == '0 &&
        (i_status != ST_NOT_FOUND || i_found == '0))
        else $error("An error result carries a nonzero read value or position.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) &&
        $stable(i_found) && $stable(i_rd) && $stable(i_count))
        else $error("A stalled result changed before its transfer.");

endmodule

bind bounded_array_list_engine bale_checker #(
    .CAPACITY (CAPACITY)
) u_bale_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_found     (o_out.found_position),
    .i_rd        (o_out.read_value),
    .i_count     (o_out.count)
);

// ===== bench/testbench.sv =====
// Self-checking testbench of the bounded array list engine with its own list predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bale_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int DRAIN_CYCLES = 4 * CAPACITY + 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_OPS   = 270;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] FILL_BASE = 32'sd1000;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
        int                       repeats;
        bit                       typed;
        t_result                  want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    bale_in_if  in_bus ();
    bale_out_if out_bus ();

    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int unsigned              list_len;

    t_result   pending_results [$];
    t_stim_row directed_rows [$];

    int mismatch_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;

    bounded_array_list_engine #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic void remove_entry(input int unsigned idx);
        for (int unsigned i = idx; i + 1 < list_len; i++) begin
            list_words[i] = list_words[i + 1];
        end
        list_len--;
    endfunction

    function automatic t_result apply_list_op(
        input logic [OP_W-1:0]          op,
        input logic signed [WORD_W-1:0] value,
        input logic [POS_W-1:0]         pos
    );
        t_result res;
        int      hit;
        res.status         = ST_OK;
        res.found_position = '0;
        res.read_value     = '0;
        hit                = -1;
        case (op)
            OP_APPEND: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = value;
                    list_len++;
                end
            end
            OP_DEL_POS: begin
                if (pos >= list_len) res.status = ST_BAD_POS;
                else remove_entry(pos);
            end
            OP_DEL_VAL, OP_FIND: begin
                for (int i = 0; i < int'(list_len); i++) begin
                    if (hit < 0 && list_words[i] == value) hit = i;
                end
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.found_position = FOUND_W'(hit);
                    if (op == OP_DEL_VAL) remove_entry(hit);
                end
            end
            OP_READ: begin
                if (pos >= list_len) res.status = ST_BAD_POS;
                else res.read_value = list_words[pos];
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    task automatic transfer_op(
        input logic [OP_W-1:0]          op,
        input logic signed [WORD_W-1:0] value,
        input logic [POS_W-1:0]         pos
    );
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.op       <= op;
        in_bus.value    <= value;
        in_bus.position <= pos;
        @(posedge i_clk);
        while (in_bus.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic add_row(
        input logic [OP_W-1:0]          op,
        input logic signed [WORD_W-1:0] value,
        input logic [POS_W-1:0]         pos,
        input int                       repeats,
        input bit                       typed,
        input t_status                  st,
        input logic [FOUND_W-1:0]       found,
        input logic signed [WORD_W-1:0] rd,
        input logic [COUNT_W-1:0]       cnt
    );
        t_stim_row r;
        r.op       = op;
        r.value    = value;
        r.position = pos;
        r.repeats  = repeats;
        r.typed    = typed;
        r.want     = '{st, found, rd, cnt};
        directed_rows.push_back(r);
    endtask

    task automatic run_directed();
        t_result predicted;
        foreach (directed_rows[n]) begin
            for (int k = 0; k < directed_rows[n].repeats; k++) begin
                transfer_op(directed_rows[n].op, directed_rows[n].value + k,
                            directed_rows[n].position);
                predicted = apply_list_op(directed_rows[n].op, directed_rows[n].value + k,
                                          directed_rows[n].position);
                pending_results.push_back(directed_rows[n].typed ? directed_rows[n].want
                                                                 : predicted);
            end
        end
    endtask

    task automatic run_random_ops(input int n);
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         pos;
        int unsigned              roll;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 36) op = OP_APPEND;
            else if (roll < 48) op = OP_DEL_POS;
            else if (roll < 60) op = OP_DEL_VAL;
            else if (roll < 76) op = OP_FIND;
            else if (roll < 94) op = OP_READ;
            else if (roll < 97) op = OP_CLEAR;
            else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;

            roll = $urandom_range(99);
            if (list_len != 0 && roll < 50) begin
                value = list_words[$urandom_range(list_len - 1)];
            end else if (roll < 65) begin
                case ($urandom_range(3))
                    0: value = WORD_MIN;
                    1: value = WORD_MAX;
                    2: value = -32'sd1;
                    default: value = '0;
                endcase
            end else begin
                value = $urandom;
            end

            if (list_len != 0 && $urandom_range(99) < 80) begin
                pos = POS_W'($urandom_range(list_len - 1));
            end else begin
                pos = POS_W'($urandom_range(31));
            end

            transfer_op(op, value, pos);
            pending_results.push_back(apply_list_op(op, value, pos));
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            report_error($sformatf("result with nothing pending: status %0d count %0d",
                                   out_bus.status, out_bus.count));
            return;
        end
        want = pending_results.pop_front();
        if (out_bus.status !== want.status)
            report_error($sformatf("status %0d, expected %0d", out_bus.status, want.status));
        if (out_bus.found_position !== want.found_position)
            report_error($sformatf("found_position %0d, expected %0d",
                                   out_bus.found_position, want.found_position));
        if (out_bus.read_value !== want.read_value)
            report_error($sformatf("read_value %0d, expected %0d",
                                   out_bus.read_value, want.read_value));
        if (out_bus.count !== want.count)
            report_error($sformatf("count %0d, expected %0d", out_bus.count, want.count));
    endtask

    initial begin
        int hold_left;
        hold_left     = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) check_result();
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        mismatch_count  = 0;
        hold_request    = 0;
        list_len        = 0;
        send_idle_pct   = 33;
        recv_idle_pct   = 67;
        in_bus.valid    <= 1'b0;
        in_bus.op       <= OP_APPEND;
        in_bus.value    <= '0;
        in_bus.position <= '0;
        i_rst_n         <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(OP_READ,    '0,          5'd0,  1, 1, ST_BAD_POS,   '0, '0,       6'd0);
        add_row(OP_DEL_POS, '0,          5'd31, 1, 1, ST_BAD_POS,   '0, '0,       6'd0);
        add_row(OP_FIND,    '0,          5'd0,  1, 1, ST_NOT_FOUND, '0, '0,       6'd0);
        add_row(OP_DEL_VAL, -32'sd1,     5'd0,  1, 1, ST_NOT_FOUND, '0, '0,       6'd0);
        add_row(OP_APPEND,  WORD_MIN,    5'd0,  1, 1, ST_OK,        '0, '0,       6'd1);
        add_row(OP_APPEND,  WORD_MAX,    5'd0,  1, 1, ST_OK,        '0, '0,       6'd2);
        add_row(OP_APPEND,  -32'sd1,     5'd0,  1, 1, ST_OK,        '0, '0,       6'd3);
        add_row(OP_APPEND,  32'sd20,     5'd0,  1, 1, ST_OK,        '0, '0,       6'd4);
        add_row(OP_APPEND,  WORD_MAX,    5'd0,  1, 1, ST_OK,        '0, '0,       6'd5);
        add_row(OP_READ,    '0,          5'd0,  1, 1, ST_OK,        '0, WORD_MIN, 6'd5);
        add_row(OP_READ,    '0,          5'd1,  1, 1, ST_OK,        '0, WORD_MAX, 6'd5);
        add_row(OP_FIND,    WORD_MAX,    5'd0,  1, 1, ST_OK,      5'd1, '0,       6'd5);
        add_row(OP_DEL_VAL, WORD_MAX,    5'd0,  1, 1, ST_OK,      5'd1, '0,       6'd4);
        add_row(OP_FIND,    WORD_MAX,    5'd0,  1, 1, ST_OK,      5'd3, '0,       6'd4);
        add_row(OP_DEL_POS, '0,          5'd0,  1, 1, ST_OK,        '0, '0,       6'd3);
        add_row(OP_READ,    '0,          5'd3,  1, 1, ST_BAD_POS,   '0, '0,       6'd3);
        add_row(OP_READ,    '0,          5'd2,  1, 1, ST_OK,        '0, WORD_MAX, 6'd3);
        add_row(OP_SPARE_A, 32'sh5A5A_A5A5, 5'd7, 1, 1, ST_OK,      '0, '0,       6'd3);
        add_row(OP_SPARE_B, -32'sd1,     5'd31, 1, 1, ST_OK,        '0, '0,       6'd3);
        add_row(OP_CLEAR,   '0,          5'd0,  1, 1, ST_OK,        '0, '0,       6'd0);
        add_row(OP_APPEND,  FILL_BASE,   5'd0, CAPACITY, 0, ST_OK,  '0, '0,       '0);
        add_row(OP_APPEND,  32'sd77,     5'd0,  1, 1, ST_FULL,      '0, '0,       6'd32);
        add_row(OP_READ,    '0,          5'd31, 1, 1, ST_OK,        '0, FILL_BASE + 31, 6'd32);
        add_row(OP_DEL_POS, '0,          5'd31, 1, 1, ST_OK,        '0, '0,       6'd31);
        add_row(OP_DEL_VAL, FILL_BASE,   5'd0,  1, 1, ST_OK,        '0, '0,       6'd30);
        add_row(OP_CLEAR,   '0,          5'd0,  1, 1, ST_OK,        '0, '0,       6'd0);
        run_directed();

        run_random_ops(RANDOM_OPS);
        send_idle_pct = 67;
        recv_idle_pct = 33;
        run_random_ops(RANDOM_OPS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        run_random_ops(RANDOM_OPS);
        in_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== bounded_array_list_engine.f =====
rtl/core/bale_pkg.sv
rtl/core/bale_if.sv
rtl/core/bale_ram.sv
rtl/core/bale_seq.sv
rtl/core/bale_out_stage.sv
rtl/core/bounded_array_list_engine.sv
rtl/core/bale_checker.sv
bench/testbench.sv
